// ----- hw/rtl/utf16be_to_utf8_transcoder_unit_defines.svh -----
// Assertion helpers shared by the transcoder RTL.
// Each macro expects clk and rst_n in scope.
`ifndef UTF16BE_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define UTF16BE_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U16U8_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transcoder check failed");

// Consequent must hold in the cycle after the antecedent.
`define U16U8_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transcoder check failed");

`endif

// ----- hw/rtl/u16u8_pkg.sv -----
package u16u8_pkg;

  // Input beat: one UTF-16 code unit and the end-of-string flag
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_beat_t;

  // Output beat: one UTF-8 byte and the end-of-run flag
  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_end;
  } out_beat_t;

  // Work handed from front to back: optional U+FFFD, then optional code point
  typedef struct packed {
    logic        has_rep;
    logic        has_cp;
    logic [20:0] cp;
  } job_t;

  localparam logic [20:0] REPL_CP  = 21'h00FFFD;
  localparam logic [2:0]  REPL_LEN = 3'd3;

  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

  localparam logic [20:0] LIM_1B = 21'h000080;
  localparam logic [20:0] LIM_2B = 21'h000800;
  localparam logic [20:0] LIM_3B = 21'h010000;

  localparam logic [1:0] CONT_TAG = 2'b10;

  // Number of UTF-8 bytes for a code point
  function automatic logic [2:0] cp_len(input logic [20:0] cp);
    logic [2:0] len;
    priority if (cp < LIM_1B) len = 3'd1;
    else if (cp < LIM_2B) len = 3'd2;
    else if (cp < LIM_3B) len = 3'd3;
    else len = 3'd4;
    return len;
  endfunction

  // Byte k of the UTF-8 form of a code point of the given length
  function automatic logic [7:0] cp_byte(input logic [20:0] cp, input logic [2:0] len,
                                         input logic [2:0] k);
    logic [7:0] b;
    unique case (len)
      3'd1: b = cp[7:0];
      3'd2: b = (k == 3'd0) ? {3'b110, cp[10:6]} : {CONT_TAG, cp[5:0]};
      3'd3: begin
        unique case (k)
          3'd0:    b = {4'b1110, cp[15:12]};
          3'd1:    b = {CONT_TAG, cp[11:6]};
          default: b = {CONT_TAG, cp[5:0]};
        endcase
      end
      default: begin
        unique case (k)
          3'd0:    b = {5'b11110, cp[20:18]};
          3'd1:    b = {CONT_TAG, cp[17:12]};
          3'd2:    b = {CONT_TAG, cp[11:6]};
          default: b = {CONT_TAG, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/u16u8_front.sv -----
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  input  logic     q_ready,
  output logic     q_push,
  output job_t     q_job
);

  logic       held_r, held_nxt;
  logic [9:0] held_bits_r, held_bits_nxt;
  logic       is_high, is_low, is_nul, accept;
  job_t       job;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  assign is_high = (in_beat.code_unit[15:10] == HI_SURR_TAG);
  assign is_low  = (in_beat.code_unit[15:10] == LO_SURR_TAG);
  assign is_nul  = (in_beat.code_unit == 16'h0000);

  // Classify the unit against the held surrogate
  always_comb begin
    job           = '0;
    held_nxt      = 1'b0;
    held_bits_nxt = 10'd0;
    if (held_r && is_low) begin
      // Join the pair: 0x10000 + (high bits << 10) + low bits
      job.has_cp = 1'b1;
      job.cp     = {({1'b0, held_bits_r} + 11'd64), in_beat.code_unit[9:0]};
    end else begin
      job.has_rep = held_r;
      priority if (is_nul) begin
        job.has_cp = 1'b0;
      end else if (is_high && !in_beat.last_unit) begin
        held_nxt      = 1'b1;
        held_bits_nxt = in_beat.code_unit[9:0];
      end else if (is_high || is_low) begin
        job.has_cp = 1'b1;
        job.cp     = REPL_CP;
      end else begin
        job.has_cp = 1'b1;
        job.cp     = {5'd0, in_beat.code_unit};
      end
    end
  end

  // Queue only units that produce bytes
  assign q_push = accept && (job.has_rep || job.has_cp);
  assign q_job  = job;

  // Hold surrogate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      held_bits_r <= 10'd0;
    end else if (accept) begin
      held_r      <= held_nxt;
      held_bits_r <= held_bits_nxt;
    end
  end

endmodule

// ----- hw/rtl/u16u8_queue.sv -----
`include "utf16be_to_utf8_transcoder_unit_defines.svh"

module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slots_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_job;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  `U16U8_ASSERT_SAME(a_count_bound, 1'b1, count_r <= FULL_CNT)
  `U16U8_ASSERT_NEXT(a_push_lands, do_push && !do_pop, count_r == $past(count_r) + 1'b1)

endmodule

// ----- hw/rtl/u16u8_back.sv -----
`include "utf16be_to_utf8_transcoder_unit_defines.svh"

module u16u8_back
  import u16u8_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  job_t      q_job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic       busy_r;
  logic       rep_r;
  logic [20:0] cp_r;
  logic [2:0] cp_len_r;
  logic [2:0] idx_r, total_r;
  logic       out_valid_r;
  out_beat_t  out_beat_r;

  logic       emit, last;
  logic [2:0] ld_len, ld_total, rep_off;
  logic [7:0] byte_nxt;

  assign emit  = busy_r && (!out_valid_r || out_ready);
  assign last  = (idx_r == total_r - 3'd1);
  assign q_pop = q_valid && (!busy_r || (emit && last));

  // Size the incoming job
  assign ld_len   = q_job.has_cp ? cp_len(q_job.cp) : 3'd0;
  assign ld_total = (q_job.has_rep ? REPL_LEN : 3'd0) + ld_len;

  // Pick the current byte: replacement first, then the code point
  assign rep_off = rep_r ? REPL_LEN : 3'd0;
  always_comb begin
    if (rep_r && (idx_r < REPL_LEN)) byte_nxt = cp_byte(REPL_CP, REPL_LEN, idx_r);
    else byte_nxt = cp_byte(cp_r, cp_len_r, idx_r - rep_off);
  end

  // Load jobs and step through their bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_r + 3'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= 3'd0;
      end else if (emit && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Job payload and output beat
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rep_r    <= q_job.has_rep;
      cp_r     <= q_job.cp;
      cp_len_r <= ld_len;
      total_r  <= ld_total;
    end
    if (emit) begin
      out_beat_r.utf8_byte <= byte_nxt;
      out_beat_r.run_end   <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `U16U8_ASSERT_SAME(a_idx_in_job, busy_r, idx_r < total_r)
  `U16U8_ASSERT_NEXT(a_run_end_tag, emit, out_valid_r && (out_beat_r.run_end == $past(last)))
  `U16U8_ASSERT_NEXT(a_load_start, q_pop, busy_r && (idx_r == 3'd0))

endmodule

// ----- hw/rtl/utf16be_to_utf8_transcoder_unit.sv -----
// A unit's job goes into the job queue, then into the back-end job registers, and
// its first byte is registered into the output beat. The back-end serializer sends
// one output byte per cycle while out_ready allows; a unit yields 0 to 6 bytes, and
// the job queue of DEPTH entries lets input run ahead of the output. Units
// yielding no bytes are not queued. Reset (rst_n low, synchronous): clears the
// held surrogate, empties the queue and drops any pending output byte.
module utf16be_to_utf8_transcoder_unit
  import u16u8_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic q_ready, q_push, q_valid, q_pop;
  job_t q_in_job, q_out_job;

  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_job    (q_in_job)
  );

  u16u8_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_job   (q_in_job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_job    (q_out_job)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_job     (q_out_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule
